FILE: rtl/core/lde94_pkg.sv
package lde94_pkg;

    // Number formats of the ports.
    localparam int FRACTION_BITS = 8;
    localparam int GUARD_BITS    = 4;
    localparam int WEIGHT_FRAC   = 12;
    localparam int SCALE_FRAC    = 16;
    localparam int SCALE_SHIFT   = FRACTION_BITS + GUARD_BITS;

    localparam int L_W       = 15;
    localparam int AB_W      = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_W     = 24;

    // Chroma square roots: (a^2 + b^2) with guard bits appended.
    localparam int SQC_W   = 2 * AB_W + 2 * GUARD_BITS;
    localparam int C_W     = SQC_W / 2;
    localparam int C_STEPS = C_W;
    localparam int SQC_TOP = SQC_W - 2;

    // Hue square root: (da^2 + db^2) with guard bits appended.
    localparam int DAB_W   = 2 * AB_W + 1 + 2 * GUARD_BITS;
    localparam int H_W     = (DAB_W + 1) / 2;
    localparam int H_STEPS = H_W;
    localparam int SQH_TOP = 2 * (H_W - 1);

    // Scaling functions and divider operands.
    localparam int K_W     = CFG_W + C_W;
    localparam int S_W     = K_W - SCALE_SHIFT + 1;
    localparam int DEN_W   = CFG_W + S_W;
    localparam int SHIFT_L = GUARD_BITS + WEIGHT_FRAC;
    localparam int SHIFT_T = WEIGHT_FRAC + SCALE_FRAC;
    localparam int NUM_W   = H_W + SHIFT_T + 1;
    localparam int Q_W     = 25 + GUARD_BITS + 1;
    localparam int D_STEPS = Q_W;
    localparam int CMP_W   = DEN_W + Q_W;
    localparam int LANES   = 3;

    // Final root of the sum of the three squared terms.
    localparam int SQ_W    = 2 * Q_W;
    localparam int R_W     = SQ_W / 2;
    localparam int R_STEPS = R_W;
    localparam int SQR_TOP = SQ_W - 2;

    localparam logic [S_W-1:0]   ONE_Q16  = S_W'(1) << SCALE_FRAC;
    localparam logic [Q_W-1:0]   TERM_CAP = Q_W'(1) << (Q_W - 1);
    localparam logic [SQ_W-1:0]  SQ_CAP   = SQ_W'(1) << (2 * (Q_W - 1));
    localparam logic [R_W:0]     ROUND_HALF = (R_W + 1)'(1) << (GUARD_BITS - 1);
    localparam logic [OUT_W-1:0] OUT_MAX  = {OUT_W{1'b1}};

    localparam logic [CFG_W-1:0] RST_LIGHTNESS_WEIGHT = 16'd4096;
    localparam logic [CFG_W-1:0] RST_CHROMA_SLOPE     = 16'd2949;
    localparam logic [CFG_W-1:0] RST_HUE_SLOPE        = 16'd983;
    localparam logic [CFG_W-1:0] RST_CHROMA_WEIGHT    = 16'd4096;
    localparam logic [CFG_W-1:0] RST_HUE_WEIGHT       = 16'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIGHTNESS_WEIGHT = 3'd0,
        REG_CHROMA_SLOPE     = 3'd1,
        REG_HUE_SLOPE        = 3'd2,
        REG_CHROMA_WEIGHT    = 3'd3,
        REG_HUE_WEIGHT       = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [Q_W-1:0]   quo;
        logic             over;
    } div_lane_t;

    function automatic logic [CFG_W-1:0] weight_eff(input logic [CFG_W-1:0] w);
        return (w == '0) ? CFG_W'(1) : w;
    endfunction

    function automatic logic [AB_W-1:0] abs_ab(input logic [AB_W-1:0] x);
        return x[AB_W-1] ? AB_W'(-x) : x;
    endfunction

    function automatic logic [AB_W-1:0] abs_diff_ab(input logic [AB_W-1:0] x,
                                                    input logic [AB_W-1:0] y);
        logic [AB_W:0] d;
        d = {x[AB_W-1], x} - {y[AB_W-1], y};
        return d[AB_W] ? AB_W'(-d) : d[AB_W-1:0];
    endfunction

endpackage

FILE: rtl/core/lab_delta_e_cie94.sv
// Channel   Direction  Handshake             Beat contents
// cfg       in         cfg_we                cfg_index, cfg_data (one weight or slope)
// in        in         in_valid / in_ready   both colours, L Q7.8, a b signed Q8.8
// out       out        out_valid / out_ready difference, CIE94 delta E, Q16.8
//
// A beat enters every cycle while the skid register is empty; its result passes
// through the chain of one-bit square root and divider stages.
// rst_n clears the configuration to its defaults and empties the pipeline.
// The output register is backed by a skid register; the pipeline only holds
// while the skid register is full, so a waiting result does not block input.
module lab_delta_e_cie94 (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lde94_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lde94_pkg::CFG_W-1:0]     cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [lde94_pkg::L_W-1:0]       first_lightness,
    input  logic signed [lde94_pkg::AB_W-1:0] first_green_red,
    input  logic signed [lde94_pkg::AB_W-1:0] first_blue_yellow,
    input  logic [lde94_pkg::L_W-1:0]       second_lightness,
    input  logic signed [lde94_pkg::AB_W-1:0] second_green_red,
    input  logic signed [lde94_pkg::AB_W-1:0] second_blue_yellow,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [lde94_pkg::OUT_W-1:0]     difference
);
    import lde94_pkg::*;

    // Configuration registers.
    logic [CFG_W-1:0] kl_reg, k1_reg, k2_reg, kc_reg, kh_reg;
    logic [CFG_W-1:0] kl_eff, kc_eff, kh_eff;

    // The whole pipeline moves as one while the skid register is empty.
    logic adv;

    // Stage 1: magnitudes and differences.
    logic             s1_valid_reg;
    logic [L_W-1:0]   s1_dl_reg, s1_dl_next;
    logic [AB_W-1:0]  s1_mag_reg [0:3];
    logic [AB_W-1:0]  s1_mag_next [0:3];
    logic [AB_W-1:0]  s1_dab_reg [0:1];
    logic [AB_W-1:0]  s1_dab_next [0:1];

    // Stage 2: squares.
    logic              s2_valid_reg;
    logic [L_W-1:0]    s2_dl_reg;
    logic [2*AB_W-1:0] s2_sq_reg [0:5];
    logic [2*AB_W-1:0] s2_sq_next [0:5];

    // Chroma root chain, two lanes.
    logic              c_valid_reg [0:C_STEPS];
    logic [L_W-1:0]    c_dl_reg [0:C_STEPS];
    logic [L_W-1:0]    c_dl_next [0:C_STEPS];
    logic [DAB_W-1:0]  c_dab_reg [0:C_STEPS];
    logic [DAB_W-1:0]  c_dab_next [0:C_STEPS];
    logic [SQC_W-1:0]  c_rem_reg [0:C_STEPS][0:1];
    logic [SQC_W-1:0]  c_rem_next [0:C_STEPS][0:1];
    logic [SQC_W-1:0]  c_root_reg [0:C_STEPS][0:1];
    logic [SQC_W-1:0]  c_root_next [0:C_STEPS][0:1];

    // Stages 4 to 6: chroma difference, scaling functions, hue square.
    logic              s4_valid_reg;
    logic [C_W-1:0]    s4_c1_reg, s4_c1_next, s4_dc_reg, s4_dc_next;
    logic [L_W-1:0]    s4_dl_reg;
    logic [DAB_W-1:0]  s4_dab_reg;
    logic              s5_valid_reg;
    logic [2*C_W-1:0]  s5_dc2_reg, s5_dc2_next;
    logic [K_W-1:0]    s5_pk1_reg, s5_pk1_next, s5_pk2_reg, s5_pk2_next;
    logic [C_W-1:0]    s5_dc_reg;
    logic [L_W-1:0]    s5_dl_reg;
    logic [DAB_W-1:0]  s5_dab_reg;
    logic              s6_valid_reg;
    logic [DAB_W-1:0]  s6_hsq_reg, s6_hsq_next;
    logic [S_W-1:0]    s6_sc_reg, s6_sc_next, s6_sh_reg, s6_sh_next;
    logic [C_W-1:0]    s6_dc_reg;
    logic [L_W-1:0]    s6_dl_reg;

    // Hue root chain; its first stage also forms the two denominators.
    logic              h_valid_reg [0:H_STEPS];
    logic [DAB_W-1:0]  h_rem_reg [0:H_STEPS];
    logic [DAB_W-1:0]  h_rem_next [0:H_STEPS];
    logic [DAB_W-1:0]  h_root_reg [0:H_STEPS];
    logic [DAB_W-1:0]  h_root_next [0:H_STEPS];
    logic [DEN_W-1:0]  h_denc_reg [0:H_STEPS];
    logic [DEN_W-1:0]  h_denc_next [0:H_STEPS];
    logic [DEN_W-1:0]  h_denh_reg [0:H_STEPS];
    logic [DEN_W-1:0]  h_denh_next [0:H_STEPS];
    logic [C_W-1:0]    h_dc_reg [0:H_STEPS];
    logic [C_W-1:0]    h_dc_next [0:H_STEPS];
    logic [L_W-1:0]    h_dl_reg [0:H_STEPS];
    logic [L_W-1:0]    h_dl_next [0:H_STEPS];

    // Divider chain, three lanes: lightness, chroma, hue.
    logic              d_valid_reg [0:D_STEPS];
    div_lane_t         d_lane_reg [0:D_STEPS][0:LANES-1];
    div_lane_t         d_lane_next [0:D_STEPS][0:LANES-1];

    // Stage 9: capped terms squared.
    logic              s9_valid_reg;
    logic [SQ_W-1:0]   s9_sq_reg [0:LANES-1];
    logic [SQ_W-1:0]   s9_sq_next [0:LANES-1];

    // Final root chain; its first stage sums the squares.
    logic              r_valid_reg [0:R_STEPS];
    logic [SQ_W-1:0]   r_rem_reg [0:R_STEPS];
    logic [SQ_W-1:0]   r_rem_next [0:R_STEPS];
    logic [SQ_W-1:0]   r_root_reg [0:R_STEPS];
    logic [SQ_W-1:0]   r_root_next [0:R_STEPS];

    // Stage 11: rounding and saturation.
    logic              s11_valid_reg;
    logic [OUT_W-1:0]  s11_diff_reg, s11_diff_next;

    // Output register and skid register.
    logic              out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]  out_data_reg, out_data_next;
    logic              skid_valid_reg, skid_valid_next;
    logic [OUT_W-1:0]  skid_data_reg, skid_data_next;

    // ------------------------------------------------------------------
    // Configuration. Writes to an index beyond the list are dropped.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kl_reg <= RST_LIGHTNESS_WEIGHT;
            k1_reg <= RST_CHROMA_SLOPE;
            k2_reg <= RST_HUE_SLOPE;
            kc_reg <= RST_CHROMA_WEIGHT;
            kh_reg <= RST_HUE_WEIGHT;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_LIGHTNESS_WEIGHT: kl_reg <= cfg_data;
                REG_CHROMA_SLOPE:     k1_reg <= cfg_data;
                REG_HUE_SLOPE:        k2_reg <= cfg_data;
                REG_CHROMA_WEIGHT:    kc_reg <= cfg_data;
                REG_HUE_WEIGHT:       kh_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // A weight of zero is taken as the smallest step.
    assign kl_eff = weight_eff(kl_reg);
    assign kc_eff = weight_eff(kc_reg);
    assign kh_eff = weight_eff(kh_reg);

    assign adv      = !skid_valid_reg;
    assign in_ready = adv;

    // ------------------------------------------------------------------
    // Stages 1 and 2: absolute values, differences and their squares.
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [L_W:0] dl;
        dl = {1'b0, first_lightness} - {1'b0, second_lightness};
        s1_dl_next     = dl[L_W] ? L_W'(-dl) : dl[L_W-1:0];
        s1_mag_next[0] = abs_ab(first_green_red);
        s1_mag_next[1] = abs_ab(first_blue_yellow);
        s1_mag_next[2] = abs_ab(second_green_red);
        s1_mag_next[3] = abs_ab(second_blue_yellow);
        s1_dab_next[0] = abs_diff_ab(first_green_red, second_green_red);
        s1_dab_next[1] = abs_diff_ab(first_blue_yellow, second_blue_yellow);
    end

    always_comb
    begin
        for (int n = 0; n < 4; n++)
        begin
            s2_sq_next[n] = (2*AB_W)'(s1_mag_reg[n]) * (2*AB_W)'(s1_mag_reg[n]);
        end
        for (int n = 0; n < 2; n++)
        begin
            s2_sq_next[4+n] = (2*AB_W)'(s1_dab_reg[n]) * (2*AB_W)'(s1_dab_reg[n]);
        end
    end

    // ------------------------------------------------------------------
    // Chroma roots, one result bit per stage.
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [SQC_W-1:0] bitv;
        logic [SQC_W:0]   trial;
        c_dl_next[0]      = s2_dl_reg;
        c_dab_next[0]     = {(s2_sq_reg[4] + (2*AB_W+1)'(s2_sq_reg[5])) + 33'd0,
                             {(2*GUARD_BITS){1'b0}}};
        c_rem_next[0][0]  = {s2_sq_reg[0] + s2_sq_reg[1], {(2*GUARD_BITS){1'b0}}};
        c_rem_next[0][1]  = {s2_sq_reg[2] + s2_sq_reg[3], {(2*GUARD_BITS){1'b0}}};
        c_root_next[0][0] = '0;
        c_root_next[0][1] = '0;
        for (int k = 1; k <= C_STEPS; k++)
        begin
            bitv = SQC_W'(1) << (SQC_TOP - 2 * (k - 1));
            c_dl_next[k]  = c_dl_reg[k-1];
            c_dab_next[k] = c_dab_reg[k-1];
            for (int n = 0; n < 2; n++)
            begin
                trial = {1'b0, c_root_reg[k-1][n]} + {1'b0, bitv};
                if ({1'b0, c_rem_reg[k-1][n]} >= trial)
                begin
                    c_rem_next[k][n]  = c_rem_reg[k-1][n] - trial[SQC_W-1:0];
                    c_root_next[k][n] = (c_root_reg[k-1][n] >> 1) + bitv;
                end
                else
                begin
                    c_rem_next[k][n]  = c_rem_reg[k-1][n];
                    c_root_next[k][n] = c_root_reg[k-1][n] >> 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 4 to 6: chroma difference, its square, SC and SH.
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [C_W-1:0] c1;
        logic [C_W-1:0] c2;
        c1 = c_root_reg[C_STEPS][0][C_W-1:0];
        c2 = c_root_reg[C_STEPS][1][C_W-1:0];
        s4_c1_next = c1;
        s4_dc_next = (c1 >= c2) ? c1 - c2 : c2 - c1;

        s5_dc2_next = (2*C_W)'(s4_dc_reg) * (2*C_W)'(s4_dc_reg);
        s5_pk1_next = K_W'(k1_reg) * K_W'(s4_c1_reg);
        s5_pk2_next = K_W'(k2_reg) * K_W'(s4_c1_reg);

        // The hue square is clamped at zero where rounding makes it negative.
        s6_hsq_next = (s5_dab_reg > DAB_W'(s5_dc2_reg))
                      ? s5_dab_reg - DAB_W'(s5_dc2_reg) : '0;
        s6_sc_next  = ONE_Q16 + S_W'(s5_pk1_reg >> SCALE_SHIFT);
        s6_sh_next  = ONE_Q16 + S_W'(s5_pk2_reg >> SCALE_SHIFT);
    end

    // ------------------------------------------------------------------
    // Hue root; the first stage multiplies out kC*SC and kH*SH.
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [DAB_W-1:0] bitv;
        logic [DAB_W:0]   trial;
        h_rem_next[0]  = s6_hsq_reg;
        h_root_next[0] = '0;
        h_denc_next[0] = DEN_W'(kc_eff) * DEN_W'(s6_sc_reg);
        h_denh_next[0] = DEN_W'(kh_eff) * DEN_W'(s6_sh_reg);
        h_dc_next[0]   = s6_dc_reg;
        h_dl_next[0]   = s6_dl_reg;
        for (int k = 1; k <= H_STEPS; k++)
        begin
            bitv = DAB_W'(1) << (SQH_TOP - 2 * (k - 1));
            h_denc_next[k] = h_denc_reg[k-1];
            h_denh_next[k] = h_denh_reg[k-1];
            h_dc_next[k]   = h_dc_reg[k-1];
            h_dl_next[k]   = h_dl_reg[k-1];
            trial = {1'b0, h_root_reg[k-1]} + {1'b0, bitv};
            if ({1'b0, h_rem_reg[k-1]} >= trial)
            begin
                h_rem_next[k]  = h_rem_reg[k-1] - trial[DAB_W-1:0];
                h_root_next[k] = (h_root_reg[k-1] >> 1) + bitv;
            end
            else
            begin
                h_rem_next[k]  = h_rem_reg[k-1];
                h_root_next[k] = h_root_reg[k-1] >> 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Rounded division, one quotient bit per stage. The first stage adds
    // half the divisor and flags quotients too wide for the quotient field.
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [DEN_W-1:0] den [0:LANES-1];
        logic [NUM_W-1:0] num [0:LANES-1];
        logic [CMP_W-1:0] shifted;
        den[0] = DEN_W'(kl_eff);
        den[1] = h_denc_reg[H_STEPS];
        den[2] = h_denh_reg[H_STEPS];
        num[0] = NUM_W'({h_dl_reg[H_STEPS], {SHIFT_L{1'b0}}}) + NUM_W'(den[0] >> 1);
        num[1] = NUM_W'({h_dc_reg[H_STEPS], {SHIFT_T{1'b0}}}) + NUM_W'(den[1] >> 1);
        num[2] = NUM_W'({h_root_reg[H_STEPS][H_W-1:0], {SHIFT_T{1'b0}}})
                 + NUM_W'(den[2] >> 1);
        for (int n = 0; n < LANES; n++)
        begin
            d_lane_next[0][n].rem  = num[n];
            d_lane_next[0][n].den  = den[n];
            d_lane_next[0][n].quo  = '0;
            d_lane_next[0][n].over = CMP_W'(num[n]) >= {den[n], {Q_W{1'b0}}};
        end
        for (int k = 1; k <= D_STEPS; k++)
        begin
            for (int n = 0; n < LANES; n++)
            begin
                d_lane_next[k][n] = d_lane_reg[k-1][n];
                shifted = CMP_W'(d_lane_reg[k-1][n].den) << (Q_W - k);
                if (CMP_W'(d_lane_reg[k-1][n].rem) >= shifted)
                begin
                    d_lane_next[k][n].rem          = d_lane_reg[k-1][n].rem
                                                     - shifted[NUM_W-1:0];
                    d_lane_next[k][n].quo[Q_W - k] = 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: cap each term and square it.
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [Q_W-1:0] t;
        for (int n = 0; n < LANES; n++)
        begin
            t = (d_lane_reg[D_STEPS][n].over || d_lane_reg[D_STEPS][n].quo > TERM_CAP)
                ? TERM_CAP : d_lane_reg[D_STEPS][n].quo;
            s9_sq_next[n] = SQ_W'(t) * SQ_W'(t);
        end
    end

    // ------------------------------------------------------------------
    // Final root; the first stage sums the three squares.
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [SQ_W-1:0] bitv;
        logic [SQ_W:0]   trial;
        r_rem_next[0]  = s9_sq_reg[0] + s9_sq_reg[1] + s9_sq_reg[2];
        r_root_next[0] = '0;
        for (int k = 1; k <= R_STEPS; k++)
        begin
            bitv  = SQ_W'(1) << (SQR_TOP - 2 * (k - 1));
            trial = {1'b0, r_root_reg[k-1]} + {1'b0, bitv};
            if ({1'b0, r_rem_reg[k-1]} >= trial)
            begin
                r_rem_next[k]  = r_rem_reg[k-1] - trial[SQ_W-1:0];
                r_root_next[k] = (r_root_reg[k-1] >> 1) + bitv;
            end
            else
            begin
                r_rem_next[k]  = r_rem_reg[k-1];
                r_root_next[k] = r_root_reg[k-1] >> 1;
            end
        end
    end

    // Stage 11: drop the guard bits with rounding, then saturate.
    always_comb
    begin
        logic [R_W:0]            rnd;
        logic [R_W-GUARD_BITS:0] res;
        rnd = {1'b0, r_root_reg[R_STEPS][R_W-1:0]} + ROUND_HALF;
        res = rnd[R_W:GUARD_BITS];
        s11_diff_next = (res > (R_W - GUARD_BITS + 1)'(OUT_MAX)) ? OUT_MAX
                                                                 : res[OUT_W-1:0];
    end

    // ------------------------------------------------------------------
    // Pipeline registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s9_valid_reg  <= 1'b0;
            s11_valid_reg <= 1'b0;
            for (int k = 0; k <= C_STEPS; k++) c_valid_reg[k] <= 1'b0;
            for (int k = 0; k <= H_STEPS; k++) h_valid_reg[k] <= 1'b0;
            for (int k = 0; k <= D_STEPS; k++) d_valid_reg[k] <= 1'b0;
            for (int k = 0; k <= R_STEPS; k++) r_valid_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg   <= in_valid;
            s2_valid_reg   <= s1_valid_reg;
            c_valid_reg[0] <= s2_valid_reg;
            for (int k = 1; k <= C_STEPS; k++) c_valid_reg[k] <= c_valid_reg[k-1];
            s4_valid_reg   <= c_valid_reg[C_STEPS];
            s5_valid_reg   <= s4_valid_reg;
            s6_valid_reg   <= s5_valid_reg;
            h_valid_reg[0] <= s6_valid_reg;
            for (int k = 1; k <= H_STEPS; k++) h_valid_reg[k] <= h_valid_reg[k-1];
            d_valid_reg[0] <= h_valid_reg[H_STEPS];
            for (int k = 1; k <= D_STEPS; k++) d_valid_reg[k] <= d_valid_reg[k-1];
            s9_valid_reg   <= d_valid_reg[D_STEPS];
            r_valid_reg[0] <= s9_valid_reg;
            for (int k = 1; k <= R_STEPS; k++) r_valid_reg[k] <= r_valid_reg[k-1];
            s11_valid_reg  <= r_valid_reg[R_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_dl_reg    <= s1_dl_next;
            s1_mag_reg   <= s1_mag_next;
            s1_dab_reg   <= s1_dab_next;
            s2_dl_reg    <= s1_dl_reg;
            s2_sq_reg    <= s2_sq_next;
            c_dl_reg     <= c_dl_next;
            c_dab_reg    <= c_dab_next;
            c_rem_reg    <= c_rem_next;
            c_root_reg   <= c_root_next;
            s4_c1_reg    <= s4_c1_next;
            s4_dc_reg    <= s4_dc_next;
            s4_dl_reg    <= c_dl_reg[C_STEPS];
            s4_dab_reg   <= c_dab_reg[C_STEPS];
            s5_dc2_reg   <= s5_dc2_next;
            s5_pk1_reg   <= s5_pk1_next;
            s5_pk2_reg   <= s5_pk2_next;
            s5_dc_reg    <= s4_dc_reg;
            s5_dl_reg    <= s4_dl_reg;
            s5_dab_reg   <= s4_dab_reg;
            s6_hsq_reg   <= s6_hsq_next;
            s6_sc_reg    <= s6_sc_next;
            s6_sh_reg    <= s6_sh_next;
            s6_dc_reg    <= s5_dc_reg;
            s6_dl_reg    <= s5_dl_reg;
            h_rem_reg    <= h_rem_next;
            h_root_reg   <= h_root_next;
            h_denc_reg   <= h_denc_next;
            h_denh_reg   <= h_denh_next;
            h_dc_reg     <= h_dc_next;
            h_dl_reg     <= h_dl_next;
            d_lane_reg   <= d_lane_next;
            s9_sq_reg    <= s9_sq_next;
            r_rem_reg    <= r_rem_next;
            r_root_reg   <= r_root_next;
            s11_diff_reg <= s11_diff_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register with skid. A beat leaving the pipeline while the
    // output register is held goes to the skid register, which then
    // stops the pipeline until the output register frees up.
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_valid_reg && out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = s11_valid_reg;
                out_data_next  = s11_diff_reg;
            end
        end
        else if (!out_valid_reg)
        begin
            out_valid_next = s11_valid_reg;
            out_data_next  = s11_diff_reg;
        end
        else if (s11_valid_reg && adv)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = s11_diff_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid  = out_valid_reg;
    assign difference = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a beat while the output register is empty");

    a_skid_catches: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready && s11_valid_reg && !skid_valid_reg)
        |=> skid_valid_reg)
        else $error("beat leaving the pipeline under a stall was not caught");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ready && skid_valid_reg)
        |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid register did not move into the output register");

    a_term_capped: assert property (@(posedge clk) disable iff (!rst_n)
        s9_valid_reg |-> (s9_sq_reg[0] <= SQ_CAP && s9_sq_reg[1] <= SQ_CAP
                          && s9_sq_reg[2] <= SQ_CAP))
        else $error("squared term exceeds the square of the cap");

endmodule
